### sv/drsort_pkg.sv
package drsort_pkg;

  // capacity of the sorting chain
  localparam int DEPTH  = 8;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int KEY_W  = 32;
  localparam int HGT_W  = 16;
  localparam int SAL_W  = 32;
  localparam int RANK_W = 3;

  // input beat
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [HGT_W-1:0]        height;
    logic [SAL_W-1:0]        salary;
    logic                    last;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [RANK_W-1:0]       rank;
    logic signed [KEY_W-1:0] record_key;
    logic [HGT_W-1:0]        record_height;
    logic [SAL_W-1:0]        record_salary;
    logic [RANK_W-1:0]       arrival_index;
    logic [RANK_W-1:0]       tallest_rank;
    logic                    overflow;
    logic                    final_res;
  } out_beat_t;

  // one stored record in a cell
  typedef struct packed {
    logic                    valid;
    logic                    tall;
    logic signed [KEY_W-1:0] key;
    logic [HGT_W-1:0]        height;
    logic [SAL_W-1:0]        salary;
    logic [RANK_W-1:0]       arrival;
  } entry_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic insert;
    logic new_tall;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_t;

endpackage

### sv/drsort_cell.sv
module drsort_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  drsort_pkg::cell_ctrl_t ctrl,
  input  drsort_pkg::entry_t     new_ent,
  input  drsort_pkg::entry_t     prev_ent,
  input  logic                   prev_cond,
  input  drsort_pkg::entry_t     next_ent,
  output drsort_pkg::entry_t     ent,
  output logic                   cond
);
  import drsort_pkg::*;

  entry_t ent_next;

  // new record belongs at or before this cell: empty or strictly lower salary
  assign cond = !ent.valid || (ent.salary < new_ent.salary);

  // insert shifts the tail down by one, emit shifts everything toward cell 0
  always_comb begin
    ent_next = ent;
    if (ctrl.shift) begin
      ent_next = next_ent;
    end else if (ctrl.insert) begin
      if (cond) begin
        if (prev_cond) begin
          ent_next = prev_ent;
          if (ctrl.new_tall) begin
            ent_next.tall = 1'b0;
          end
        end else begin
          ent_next = new_ent;
        end
      end else if (ctrl.new_tall) begin
        ent_next.tall = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      ent.tall  <= 1'b0;
    end else begin
      ent <= ent_next;
    end
  end

endmodule

### sv/descending_record_sort_with_argmax_core.sv
// Descending record sorter with tallest-record lookup.
// Input channel in_valid / in_stall / in_data carries one record per beat
// (key, height, salary, last). Records enter an insertion chain of DEPTH
// cells at one record per cycle; each record is placed after all stored
// records of equal or higher salary, so equal salaries keep arrival order.
// Records beyond DEPTH are dropped and flag overflow for the set.
// The beat with last set closes the set: the block then raises in_stall and
// emits one result per stored record on out_valid / out_stall / out_data,
// highest salary first, one result per cycle while the receiver takes them.
// After the last beat is accepted, the state register turns to emit and each
// result is loaded from cell 0 into the output register. The emit drains
// the cell chain toward cell 0, one shift per result.
// tallest_rank is tracked during insertion, so it is ready with the first
// result. When the receiver stalls, the output register holds its result
// and the chain waits; while collecting, input beats are taken even if the
// final result of the previous set still waits in the output register.
// Synchronous reset empties the chain and clears count and overflow.
module descending_record_sort_with_argmax_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  drsort_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output drsort_pkg::out_beat_t out_data
);
  import drsort_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count;
  logic               dropped;
  logic [HGT_W-1:0]   best_height;
  logic [IDX_W-1:0]   tallest;
  logic [IDX_W-1:0]   emit_idx;

  entry_t             ents [DEPTH];
  logic [DEPTH-1:0]   conds;
  logic [DEPTH-1:0]   ins_hot;
  logic [IDX_W-1:0]   ins_pos;
  logic               flag_moves;
  entry_t             new_ent;
  cell_ctrl_t         ctrl;

  logic               accept;
  logic               full;
  logic               load;
  logic               last_load;

  assign full   = (count == CNT_W'(DEPTH));
  assign accept = in_valid && !in_stall;

  // tallest cell sits at or after the insertion point
  always_comb begin
    flag_moves = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      flag_moves = flag_moves | (ents[i].valid & ents[i].tall & conds[i]);
    end
  end

  // insertion point: first cell whose condition holds
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      ins_hot[i] = conds[i] & ((i == 0) ? 1'b1 : !conds[(i == 0) ? 0 : i - 1]);
      if (ins_hot[i]) begin
        ins_pos = ins_pos | IDX_W'(i);
      end
    end
  end

  // record as it enters the chain
  always_comb begin
    new_ent.valid   = 1'b1;
    new_ent.key     = in_data.key;
    new_ent.height  = in_data.height;
    new_ent.salary  = in_data.salary;
    new_ent.arrival = RANK_W'(count);
    new_ent.tall    = (count == '0) || (in_data.height > best_height) ||
                      ((in_data.height == best_height) && flag_moves);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (accept && in_data.last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (last_load) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall    = 1'b1;
    load        = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    case (state)
      ST_COLLECT: begin
        in_stall    = 1'b0;
        ctrl.insert = accept && !full;
      end
      ST_EMIT: begin
        load       = !out_valid || !out_stall;
        ctrl.shift = load;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    ctrl.new_tall = new_ent.tall;
  end

  assign last_load = load && ((CNT_W'(emit_idx) + CNT_W'(1)) == count);

  // the cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_c;
    if (g == 0) begin : g_head
      assign prev_e = new_ent;
      assign prev_c = 1'b0;
    end else begin : g_mid
      assign prev_e = ents[g-1];
      assign prev_c = conds[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_body
      assign next_e = ents[g+1];
    end
    drsort_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_ent   (new_ent),
      .prev_ent  (prev_e),
      .prev_cond (prev_c),
      .next_ent  (next_e),
      .ent       (ents[g]),
      .cond      (conds[g])
    );
  end

  // set bookkeeping and tallest tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_COLLECT;
      count    <= '0;
      dropped  <= 1'b0;
      tallest  <= '0;
      emit_idx <= '0;
    end else begin
      state <= state_next;
      if (ctrl.insert) begin
        count <= count + CNT_W'(1);
        if (new_ent.tall) begin
          tallest <= ins_pos;
        end else if (flag_moves) begin
          tallest <= tallest + IDX_W'(1);
        end
      end else if (accept && full) begin
        dropped <= 1'b1;
      end
      if (load) begin
        if (last_load) begin
          emit_idx <= '0;
          count    <= '0;
          dropped  <= 1'b0;
          tallest  <= '0;
        end else begin
          emit_idx <= emit_idx + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && new_ent.tall) begin
      best_height <= in_data.height;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.rank          <= RANK_W'(emit_idx);
      out_data.record_key    <= ents[0].key;
      out_data.record_height <= ents[0].height;
      out_data.record_salary <= ents[0].salary;
      out_data.arrival_index <= ents[0].arrival;
      out_data.tallest_rank  <= RANK_W'(tallest);
      out_data.overflow      <= dropped;
      out_data.final_res     <= last_load;
    end
  end

endmodule

### sv/drsort_checker.sv
module drsort_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input drsort_pkg::out_beat_t out_data
);
  import drsort_pkg::*;

  logic out_beat;
  logic in_beat;

  assign out_beat = out_valid && !out_stall;
  assign in_beat  = in_valid && !in_stall;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input stays closed while a run still has results to come
  a_closed_in_run: assert property (@(posedge clk) disable iff (rst)
    out_beat && !out_data.final_res |-> in_stall && !in_beat)
    else $error("input open during emit");

  // ranks count up by one within a run
  a_rank_step: assert property (@(posedge clk) disable iff (rst)
    out_beat && !out_data.final_res |=>
      !out_valid || (out_data.rank == RANK_W'($past(out_data.rank) + RANK_W'(1))))
    else $error("rank sequence broken");

  // run-wide fields stay the same across a run
  a_run_fields: assert property (@(posedge clk) disable iff (rst)
    out_beat && !out_data.final_res |=>
      !out_valid || ((out_data.tallest_rank == $past(out_data.tallest_rank)) &&
                     (out_data.overflow == $past(out_data.overflow))))
    else $error("run fields changed");

  // the first result of a run has rank zero
  a_first_rank: assert property (@(posedge clk) disable iff (rst)
    out_beat && out_data.final_res |=>
      !out_valid || out_data.rank == '0 || out_stall)
    else $error("run did not start at rank zero");

endmodule

bind descending_record_sort_with_argmax_core drsort_checker u_drsort_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### verif/descending_record_sort_with_argmax_core_tb.sv
`timescale 1ns / 100ps

module descending_record_sort_with_argmax_core_tb;
  import drsort_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TARGET_RECORDS = 410;
  localparam int DRAIN_CYCLES = 24;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } stim_row_t;

  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic [HGT_W-1:0]        height;
    logic [SAL_W-1:0]        salary;
    logic [RANK_W-1:0]       arrival;
  } held_rec_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  // predictor state: records of the open set and its drop flag
  held_rec_t held_q[$];
  bit        set_dropped;

  out_beat_t sorted_q[$];
  stim_row_t dir_rows[$];
  out_beat_t got_want;

  bit calm = 1'b0;
  int errors = 0;
  int cycles = 0;
  int n_records = 0;
  int n_sets = 0;
  int n_dropped_sets = 0;
  int n_results = 0;

  descending_record_sort_with_argmax_core u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sorted_q.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic stim_row_t rec(logic signed [KEY_W-1:0] k, logic [HGT_W-1:0] h,
                                    logic [SAL_W-1:0] s, logic l);
    stim_row_t r;
    r.beat.key    = k;
    r.beat.height = h;
    r.beat.salary = s;
    r.beat.last   = l;
    r.typed       = 1'b0;
    r.want        = '0;
    return r;
  endfunction

  // random record, biased toward ties and extremes
  function automatic stim_row_t rand_record(logic l);
    logic [HGT_W-1:0] h;
    logic [SAL_W-1:0] s;
    case ($urandom_range(4))
      0: h = HGT_W'($urandom_range(2));
      1: h = '1;
      default: h = HGT_W'($urandom);
    endcase
    case ($urandom_range(5))
      0: s = SAL_W'($urandom_range(3));
      1: s = '1;
      2: s = '0;
      default: s = $urandom;
    endcase
    return rec($urandom, h, s, l);
  endfunction

  // store a record; on the closing beat sort the set by salary, stable,
  // and locate the first tallest record in sorted order
  task automatic predict_sorted(input in_beat_t b, output out_beat_t res[$]);
    held_rec_t r;
    held_rec_t by_salary[$];
    int pos;
    int tallest;
    res = {};
    if (held_q.size() < DEPTH) begin
      r.key     = b.key;
      r.height  = b.height;
      r.salary  = b.salary;
      r.arrival = RANK_W'(held_q.size());
      held_q.push_back(r);
    end else begin
      set_dropped = 1'b1;
    end
    if (!b.last) return;

    // insertion after every record of equal or higher salary
    foreach (held_q[i]) begin
      pos = by_salary.size();
      for (int j = 0; j < by_salary.size(); j++) begin
        if (by_salary[j].salary < held_q[i].salary) begin
          pos = j;
          break;
        end
      end
      by_salary.insert(pos, held_q[i]);
    end

    tallest = 0;
    foreach (by_salary[i])
      if (by_salary[i].height > by_salary[tallest].height) tallest = i;

    foreach (by_salary[i]) begin
      res.push_back('{rank: RANK_W'(i), record_key: by_salary[i].key,
                      record_height: by_salary[i].height,
                      record_salary: by_salary[i].salary,
                      arrival_index: by_salary[i].arrival,
                      tallest_rank: RANK_W'(tallest), overflow: set_dropped,
                      final_res: (i == by_salary.size() - 1)});
    end
    n_sets++;
    if (set_dropped) n_dropped_sets++;
    held_q = {};
    set_dropped = 1'b0;
  endtask

  // drive one record beat, wait for acceptance, then queue its results
  task automatic send_record(input stim_row_t r);
    out_beat_t res[$];
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r.beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_records++;
    predict_sorted(r.beat, res);
    if (r.typed) sorted_q.push_back(r.want);
    else foreach (res[i]) sorted_q.push_back(res[i]);
    @(negedge clk);
  endtask

  // hold off new records until every sorted result has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (sorted_q.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want_v, got_v);
    end
  endtask

  // receiver stall
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 13);
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (sorted_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing got %p", $time, out_data);
      end else begin
        got_want = sorted_q.pop_front();
        check_field("rank", got_want.rank, out_data.rank);
        check_field("record_key", got_want.record_key, out_data.record_key);
        check_field("record_height", got_want.record_height, out_data.record_height);
        check_field("record_salary", got_want.record_salary, out_data.record_salary);
        check_field("arrival_index", got_want.arrival_index, out_data.arrival_index);
        check_field("tallest_rank", got_want.tallest_rank, out_data.tallest_rank);
        check_field("overflow", got_want.overflow, out_data.overflow);
        check_field("final_res", got_want.final_res, out_data.final_res);
      end
    end
  end

  initial begin
    stim_row_t r;
    int set_len;

    held_q = {};
    set_dropped = 1'b0;

    // single-record sets at both extremes
    r = rec(32'sh8000_0000, 16'h0000, 32'h0000_0000, 1'b1);
    r.typed = 1'b1;
    r.want = '{rank: 3'd0, record_key: 32'sh8000_0000, record_height: 16'h0000,
               record_salary: 32'h0000_0000, arrival_index: 3'd0, tallest_rank: 3'd0,
               overflow: 1'b0, final_res: 1'b1};
    dir_rows.push_back(r);
    r = rec(32'sh7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    r.typed = 1'b1;
    r.want = '{rank: 3'd0, record_key: 32'sh7FFF_FFFF, record_height: 16'hFFFF,
               record_salary: 32'hFFFF_FFFF, arrival_index: 3'd0, tallest_rank: 3'd0,
               overflow: 1'b0, final_res: 1'b1};
    dir_rows.push_back(r);
    // equal salaries keep arrival order, equal heights pick the lower rank
    dir_rows.push_back(rec(32'sd1, 16'd500, 32'd1000, 1'b0));
    dir_rows.push_back(rec(32'sd2, 16'd500, 32'd1000, 1'b0));
    dir_rows.push_back(rec(32'sd3, 16'd100, 32'd1000, 1'b1));
    // exactly full set, rising salary, several tallest records
    dir_rows.push_back(rec(32'sd10, 16'd5, 32'd100, 1'b0));
    dir_rows.push_back(rec(32'sd11, 16'd9, 32'd200, 1'b0));
    dir_rows.push_back(rec(32'sd12, 16'd3, 32'd300, 1'b0));
    dir_rows.push_back(rec(32'sd13, 16'd9, 32'd400, 1'b0));
    dir_rows.push_back(rec(32'sd14, 16'd1, 32'd500, 1'b0));
    dir_rows.push_back(rec(32'sd15, 16'd2, 32'd600, 1'b0));
    dir_rows.push_back(rec(32'sd16, 16'd9, 32'd700, 1'b0));
    dir_rows.push_back(rec(32'sd17, 16'd0, 32'd800, 1'b1));
    // set past capacity, the closing record itself dropped
    dir_rows.push_back(rec(-32'sd1, 16'hFFFF, 32'd7, 1'b0));
    dir_rows.push_back(rec(-32'sd2, 16'h0000, 32'd3, 1'b0));
    dir_rows.push_back(rec(-32'sd3, 16'hFFFF, 32'd7, 1'b0));
    dir_rows.push_back(rec(32'sd4, 16'h1234, 32'd0, 1'b0));
    dir_rows.push_back(rec(32'sd5, 16'h00FF, 32'hFFFF_FFFF, 1'b0));
    dir_rows.push_back(rec(32'sd6, 16'h8000, 32'd3, 1'b0));
    dir_rows.push_back(rec(32'sd7, 16'h7FFF, 32'd1, 1'b0));
    dir_rows.push_back(rec(32'sd8, 16'hFFFE, 32'd7, 1'b0));
    dir_rows.push_back(rec(32'sd9, 16'hFFFF, 32'd99, 1'b0));
    dir_rows.push_back(rec(32'sd10, 16'hFFFF, 32'd5, 1'b1));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (dir_rows[i]) send_record(dir_rows[i]);
    wait_for_drain();

    // random sets, mostly within capacity, some overflowing
    while (n_records < TARGET_RECORDS) begin
      calm = (n_records >= 180 && n_records < 280);
      if ($urandom_range(5) == 0) set_len = $urandom_range(DEPTH + 1, DEPTH + 4);
      else set_len = $urandom_range(1, DEPTH);
      for (int i = 0; i < set_len; i++) send_record(rand_record(i == set_len - 1));
      if ($urandom_range(9) == 0) wait_for_drain();
    end
    calm = 1'b0;

    // drain and watch for stray results
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sorted %0d sets from %0d records, %0d of them past capacity",
             n_sets, n_records, n_dropped_sets);
    $display("%0d result beats compared field by field, %0d mismatches", n_results, errors);
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
